[design/ims_pkg.sv]
package ims_pkg;

  // Lattice geometry
  localparam int unsigned SIDE  = 128;
  localparam int unsigned IDX_W = $clog2(SIDE);
  localparam int unsigned POS_W = 7;

  typedef logic [IDX_W-1:0] idx_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 1'b1;

  // Item commands
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_TRIAL  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Which lattice row the read port fetches
  typedef enum logic [1:0] {
    SEL_UP  = 2'd0,
    SEL_MID = 2'd1,
    SEL_DN  = 2'd2
  } row_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     rd_en;
    row_sel_e rd_sel;
    logic     cap_up;
    logic     cap_mid;
    logic     exec;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_trial;
  } ctrl_status_t;

  // Position taken modulo the lattice side
  function automatic idx_t wrap_idx(logic [POS_W-1:0] v);
    return idx_t'(v % SIDE);
  endfunction

  // Periodic neighbors
  function automatic idx_t prev_idx(idx_t i);
    return (i == '0) ? idx_t'(SIDE - 1) : idx_t'(i - 1'b1);
  endfunction

  function automatic idx_t next_idx(idx_t i);
    return (i == idx_t'(SIDE - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

endpackage

[design/ising_metropolis_spin_update.sv]
// Metropolis single-spin-flip engine for a 128 x 128 periodic Ising lattice
// held in an on-chip row memory (lattice contents are undefined until each
// site is loaded). Each input beat produces exactly one result beat. Load,
// report and the unused command go straight to execute; a trial takes
// longer, because the three rows around the site (above, the site's own,
// below) are fetched one after another through the single read port of the
// lattice memory before the flip decision and write-back. A finished
// result sits in an output register, so the next beat is taken while it
// waits; execution stalls only while that register is still full.
// Thresholds are unsigned 0.32 fractions; a +2 or +4 flip is accepted when
// the random word is at most the matching threshold. Write configuration
// only while the block is idle.
module ising_metropolis_spin_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [ims_pkg::POS_W-1:0]      column_i,
  input  logic [ims_pkg::POS_W-1:0]      row_i,
  input  logic                           spin_value_i,
  input  logic [31:0]                    random_word_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           flipped_o,
  output logic                           spin_after_o,
  output logic signed [3:0]              local_value_o,
  output logic signed [18:0]             energy_change_o,
  output logic signed [16:0]             magnetization_change_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ims_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import ims_pkg::*;

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  // Sequencer
  ims_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (ctrl_status),
    .cmd_o       (ctrl_cmd)
  );

  // Lattice, accumulators and result
  ims_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .command_i              (command_i),
    .column_i               (column_i),
    .row_i                  (row_i),
    .spin_value_i           (spin_value_i),
    .random_word_i          (random_word_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .cmd_i                  (ctrl_cmd),
    .status_o               (ctrl_status),
    .flipped_o              (flipped_o),
    .spin_after_o           (spin_after_o),
    .local_value_o          (local_value_o),
    .energy_change_o        (energy_change_o),
    .magnetization_change_o (magnetization_change_o)
  );

endmodule

[design/ims_ctrl.sv]
module ims_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  ims_pkg::ctrl_status_t status_i,
  output ims_pkg::ctrl_cmd_t    cmd_o
);
  import ims_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_UP  = 5'b00010,
    S_RD_MID = 5'b00100,
    S_RD_DN  = 5'b01000,
    S_EXEC   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire, out_fire, out_free;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer: trials fetch three rows, other commands go straight to execute
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = SEL_UP;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.in_is_trial ? S_RD_UP : S_EXEC;
        end
      end
      S_RD_UP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_UP;
        state_d = S_RD_MID;
      end
      S_RD_MID: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_MID;
        cmd_o.cap_up = 1'b1;
        state_d = S_RD_DN;
      end
      S_RD_DN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = SEL_DN;
        cmd_o.cap_mid = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output slot: filled on execute, emptied when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Execute never overwrites a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || !out_stall_i))
    else $error("execute while output slot busy");

  // An accepted beat always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted beat not processed");

  // A new result appears only after an execute step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.exec))
    else $error("result without execute");

endmodule

[design/ims_dp.sv]
module ims_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [1:0]                           command_i,
  input  logic [ims_pkg::POS_W-1:0]            column_i,
  input  logic [ims_pkg::POS_W-1:0]            row_i,
  input  logic                                 spin_value_i,
  input  logic [31:0]                          random_word_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ims_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  ims_pkg::ctrl_cmd_t                   cmd_i,
  output ims_pkg::ctrl_status_t                status_o,
  output logic                                 flipped_o,
  output logic                                 spin_after_o,
  output logic signed [3:0]                    local_value_o,
  output logic signed [18:0]                   energy_change_o,
  output logic signed [16:0]                   magnetization_change_o
);
  import ims_pkg::*;

  localparam logic signed [17:0] E_ACC_MAX = 18'sd131071;
  localparam logic signed [17:0] E_ACC_MIN = -18'sd131072;
  localparam logic signed [15:0] M_ACC_MAX = 16'sd32767;
  localparam logic signed [15:0] M_ACC_MIN = -16'sd32768;
  localparam logic signed [18:0] E_OUT_MAX = 19'sd131072;
  localparam logic signed [18:0] E_OUT_MIN = -19'sd131072;
  localparam logic signed [16:0] M_OUT_MAX = 17'sd32768;
  localparam logic signed [16:0] M_OUT_MIN = -17'sd32768;

  // Item registers
  cmd_e        cmd_q;
  idx_t        row_q, col_q;
  logic        spin_q;
  logic [31:0] rnd_q;

  // Thresholds and accumulators
  logic [31:0]        thr_two_q, thr_four_q;
  logic signed [17:0] e_sum_q;
  logic signed [15:0] m_sum_q;

  // Lattice memory, one row per word
  logic [SIDE-1:0] lat_mem_q [SIDE];
  logic [SIDE-1:0] rd_data_q;
  idx_t            rd_addr;
  logic            wr_en, wr_bit;

  // Gathered neighborhood bits
  logic up_q, left_q, self_q, right_q;

  // Execute-step signals
  logic               dn_bit;
  logic [2:0]         agree;
  logic [4:0]         twice_agree;
  logic signed [3:0]  local_val;
  logic               accept;
  logic signed [18:0] e_add;
  logic signed [17:0] e_next;
  logic signed [16:0] m_add;
  logic signed [15:0] m_next;
  logic signed [18:0] e_twice, e_rep;
  logic signed [16:0] m_twice, m_rep;

  // Next result beat
  logic               flipped_d, spin_after_d;
  logic signed [3:0]  local_value_d;
  logic signed [18:0] energy_change_d;
  logic signed [16:0] magnetization_change_d;

  assign status_o.in_is_trial = (cmd_e'(command_i) == CMD_TRIAL);
  assign cfg_ready_o = 1'b1;

  // Capture the incoming beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      row_q  <= wrap_idx(row_i);
      col_q  <= wrap_idx(column_i);
      spin_q <= spin_value_i;
      rnd_q  <= random_word_i;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_two_q  <= '0;
      thr_four_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_THR_TWO) begin
        thr_two_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_THR_FOUR) begin
        thr_four_q <= cfg_data_i;
      end
    end
  end

  // Read row address
  always_comb begin
    case (cmd_i.rd_sel)
      SEL_UP:  rd_addr = prev_idx(row_q);
      SEL_MID: rd_addr = row_q;
      SEL_DN:  rd_addr = next_idx(row_q);
      default: rd_addr = row_q;
    endcase
  end

  // Lattice memory: registered read, single-bit write
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= lat_mem_q[rd_addr];
    end
    if (wr_en) begin
      lat_mem_q[row_q][col_q] <= wr_bit;
    end
  end

  // Pick the needed bits out of the fetched rows
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_up) begin
      up_q <= rd_data_q[col_q];
    end
    if (cmd_i.cap_mid) begin
      left_q  <= rd_data_q[prev_idx(col_q)];
      self_q  <= rd_data_q[col_q];
      right_q <= rd_data_q[next_idx(col_q)];
    end
  end

  // Local value and acceptance; the lower row is still on the read port
  always_comb begin
    dn_bit      = rd_data_q[col_q];
    agree       = {2'b00, left_q ~^ self_q} + {2'b00, right_q ~^ self_q}
                + {2'b00, up_q ~^ self_q} + {2'b00, dn_bit ~^ self_q};
    twice_agree = {1'b0, agree, 1'b0};
    local_val   = 4'(twice_agree - 5'd4);
    accept      = (agree <= 3'd2)
               || ((agree == 3'd3) && (rnd_q <= thr_two_q))
               || ((agree == 3'd4) && (rnd_q <= thr_four_q));
  end

  // Saturating accumulator updates
  always_comb begin
    e_add  = {e_sum_q[17], e_sum_q} + 19'(local_val);
    e_next = e_sum_q;
    if (e_add[18] != e_add[17]) begin
      e_next = e_add[18] ? E_ACC_MIN : E_ACC_MAX;
    end else begin
      e_next = e_add[17:0];
    end
    // flipped spin is the inverse of the old one
    m_add  = {m_sum_q[15], m_sum_q} + (self_q ? -17'sd1 : 17'sd1);
    if (m_add[16] != m_add[15]) begin
      m_next = m_add[16] ? M_ACC_MIN : M_ACC_MAX;
    end else begin
      m_next = m_add[15:0];
    end
  end

  // Report values: twice each sum, clamped
  always_comb begin
    e_twice = {e_sum_q, 1'b0};
    m_twice = {m_sum_q, 1'b0};
    if (e_twice > E_OUT_MAX) begin
      e_rep = E_OUT_MAX;
    end else if (e_twice < E_OUT_MIN) begin
      e_rep = E_OUT_MIN;
    end else begin
      e_rep = e_twice;
    end
    if (m_twice > M_OUT_MAX) begin
      m_rep = M_OUT_MAX;
    end else if (m_twice < M_OUT_MIN) begin
      m_rep = M_OUT_MIN;
    end else begin
      m_rep = m_twice;
    end
  end

  // Lattice write on load or accepted flip
  always_comb begin
    wr_en  = 1'b0;
    wr_bit = spin_q;
    if (cmd_i.exec) begin
      case (cmd_q)
        CMD_LOAD: begin
          wr_en  = 1'b1;
          wr_bit = spin_q;
        end
        CMD_TRIAL: begin
          wr_en  = accept;
          wr_bit = ~self_q;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_sum_q <= '0;
      m_sum_q <= '0;
    end else if (cmd_i.exec) begin
      case (cmd_q)
        CMD_TRIAL: begin
          if (accept) begin
            e_sum_q <= e_next;
            m_sum_q <= m_next;
          end
        end
        CMD_REPORT: begin
          e_sum_q <= '0;
          m_sum_q <= '0;
        end
        default: begin
          e_sum_q <= e_sum_q;
          m_sum_q <= m_sum_q;
        end
      endcase
    end
  end

  // Result fields of the executed beat
  always_comb begin
    flipped_d              = 1'b0;
    spin_after_d           = 1'b0;
    local_value_d          = '0;
    energy_change_d        = '0;
    magnetization_change_d = '0;
    case (cmd_q)
      CMD_LOAD: spin_after_d = spin_q;
      CMD_TRIAL: begin
        flipped_d     = accept;
        spin_after_d  = accept ? ~self_q : self_q;
        local_value_d = local_val;
      end
      CMD_REPORT: begin
        energy_change_d        = e_rep;
        magnetization_change_d = m_rep;
      end
      default: flipped_d = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      flipped_o              <= flipped_d;
      spin_after_o           <= spin_after_d;
      local_value_o          <= local_value_d;
      energy_change_o        <= energy_change_d;
      magnetization_change_o <= magnetization_change_d;
    end
  end

  // A report leaves both sums cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (cmd_q == CMD_REPORT)) |=> ((e_sum_q == '0) && (m_sum_q == '0)))
    else $error("sums not cleared by report");

endmodule

[tb/tb_ising_metropolis_spin_update.sv]
module tb_ising_metropolis_spin_update;
  import ims_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned N_PHASES    = 5;
  localparam int unsigned N_DIRECTED  = 23;

  // One input beat and one result beat
  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  col;
    logic [6:0]  row;
    logic        spin;
    logic [31:0] rnd;
  } item_t;

  typedef struct packed {
    logic               flipped;
    logic               spin_after;
    logic signed [3:0]  lval;
    logic signed [18:0] energy;
    logic signed [16:0] magnet;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam result_t RES_ZERO = '0;
  localparam result_t RES_UP   = '{1'b0, 1'b1, 4'sd0, 19'sd0, 17'sd0};

  // Directed part: wrap corner cluster at (0,0), every accept path, extremes
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{CMD_REPORT, 7'd0,   7'd0,   1'b0, 32'h0000_0000}, 1'b1, RES_ZERO},
    '{'{CMD_NONE,   7'd127, 7'd127, 1'b1, 32'hFFFF_FFFF}, 1'b1, RES_ZERO},
    '{'{CMD_LOAD,   7'd0,   7'd0,   1'b1, 32'h0000_0000}, 1'b1, RES_UP},
    '{'{CMD_LOAD,   7'd127, 7'd0,   1'b1, 32'hFFFF_FFFF}, 1'b1, RES_UP},
    '{'{CMD_LOAD,   7'd1,   7'd0,   1'b1, 32'h0000_0000}, 1'b1, RES_UP},
    '{'{CMD_LOAD,   7'd0,   7'd127, 1'b1, 32'h0000_0000}, 1'b1, RES_UP},
    '{'{CMD_LOAD,   7'd0,   7'd1,   1'b1, 32'h0000_0000}, 1'b1, RES_UP},
    // +4 with random word equal to a zero threshold
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'h0000_0000}, 1'b0, RES_ZERO},
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b1, 32'hFFFF_FFFF}, 1'b0, RES_ZERO},
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'h0000_0001}, 1'b0, RES_ZERO},
    '{'{CMD_LOAD,   7'd0,   7'd1,   1'b0, 32'h0000_0000}, 1'b1, RES_ZERO},
    // +2 and -2 paths
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'h0000_0000}, 1'b0, RES_ZERO},
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'hFFFF_FFFF}, 1'b0, RES_ZERO},
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'h0000_0001}, 1'b0, RES_ZERO},
    '{'{CMD_LOAD,   7'd127, 7'd0,   1'b0, 32'h0000_0000}, 1'b1, RES_ZERO},
    // zero local value always flips
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b1, 32'hFFFF_FFFF}, 1'b0, RES_ZERO},
    '{'{CMD_REPORT, 7'd127, 7'd127, 1'b1, 32'hFFFF_FFFF}, 1'b0, RES_ZERO},
    '{'{CMD_LOAD,   7'd127, 7'd127, 1'b1, 32'hFFFF_FFFF}, 1'b1, RES_UP},
    '{'{CMD_LOAD,   7'd85,  7'd42,  1'b0, 32'h5555_5555}, 1'b1, RES_ZERO},
    '{'{CMD_LOAD,   7'd42,  7'd85,  1'b1, 32'hAAAA_AAAA}, 1'b1, RES_UP},
    // accumulators were cleared by the previous report
    '{'{CMD_REPORT, 7'd0,   7'd0,   1'b0, 32'h0000_0000}, 1'b1, RES_ZERO},
    '{'{CMD_NONE,   7'd0,   7'd0,   1'b0, 32'h0000_0000}, 1'b1, RES_ZERO},
    '{'{CMD_TRIAL,  7'd0,   7'd0,   1'b0, 32'h8000_0000}, 1'b0, RES_ZERO}
  };

  // Threshold settings per random phase: {two, four}
  localparam logic [63:0] PHASE_THR [N_PHASES] = '{
    {32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {32'h8000_0000, 32'h2000_0000},
    {32'h0000_0000, 32'h0000_0000},
    {32'h0000_0000, 32'hFFFF_FFFF},
    {32'h0000_0000, 32'h0000_0000}   // replaced by random values
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_NONE;
  logic [6:0]  column = '0;
  logic [6:0]  row = '0;
  logic        spin_value = 1'b0;
  logic [31:0] random_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        flipped;
  logic        spin_after;
  logic signed [3:0]  local_value;
  logic signed [18:0] energy_change;
  logic signed [16:0] magnetization_change;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THR_TWO;
  logic [31:0] cfg_data = '0;

  // Predictor state
  logic        lattice_spin   [SIDE*SIDE];
  bit          lattice_loaded [SIDE*SIDE];
  logic [31:0] thr_two = '0;
  logic [31:0] thr_four = '0;
  int          energy_sum = 0;
  int          magnet_sum = 0;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  ising_metropolis_spin_update DUT (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .command_i              (command),
    .column_i               (column),
    .row_i                  (row),
    .spin_value_i           (spin_value),
    .random_word_i          (random_word),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .flipped_o              (flipped),
    .spin_after_o           (spin_after),
    .local_value_o          (local_value),
    .energy_change_o        (energy_change),
    .magnetization_change_o (magnetization_change),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int spin_at(int r, int c);
    return lattice_spin[r*SIDE + c] ? 1 : -1;
  endfunction

  // Expected result of one beat; updates lattice and sweep sums
  function automatic result_t predict_spin_update(item_t it);
    result_t res;
    int      c, r, s, nsum, lval;
    bit      accept;
    res = '0;
    c = int'(it.col) % SIDE;
    r = int'(it.row) % SIDE;
    case (it.cmd)
      CMD_LOAD: begin
        lattice_spin[r*SIDE + c]   = it.spin;
        lattice_loaded[r*SIDE + c] = 1'b1;
        res.spin_after = it.spin;
      end
      CMD_TRIAL: begin
        s = spin_at(r, c);
        nsum = spin_at(r, (c + SIDE - 1) % SIDE) + spin_at(r, (c + 1) % SIDE)
             + spin_at((r + SIDE - 1) % SIDE, c) + spin_at((r + 1) % SIDE, c);
        lval = nsum * s;
        if (lval <= 0)      accept = 1'b1;
        else if (lval == 2) accept = (it.rnd <= thr_two);
        else                accept = (it.rnd <= thr_four);
        if (accept) begin
          s = -s;
          lattice_spin[r*SIDE + c] = (s > 0);
          energy_sum  = clamp_to(energy_sum + lval, -131072, 131071);
          magnet_sum  = clamp_to(magnet_sum + s, -32768, 32767);
          res.flipped = 1'b1;
        end
        res.lval       = 4'(lval);
        res.spin_after = (s > 0);
      end
      CMD_REPORT: begin
        res.energy = 19'(clamp_to(2 * energy_sum, -131072, 131072));
        res.magnet = 17'(clamp_to(2 * magnet_sum, -32768, 32768));
        energy_sum = 0;
        magnet_sum = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Send one beat, with random idle cycles ahead of it
  task automatic send_item(item_t it, logic typed, result_t want);
    result_t res;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= it.cmd;
    column      <= it.col;
    row         <= it.row;
    spin_value  <= it.spin;
    random_word <= it.rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_spin_update(it);
    pending_results.push_back(typed ? want : res);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_THR_TWO) thr_two = data;
    else                    thr_four = data;
  endtask

  // Result check and output-side stalling
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("flipped", flipped, want.flipped);
        check_field("spin_after", spin_after, want.spin_after);
        check_field("local_value", local_value, want.lval);
        check_field("energy_change", energy_change, want.energy);
        check_field("magnetization_change", magnetization_change, want.magnet);
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 28);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** ising_metropolis_spin_update: FAILED **");
    $finish;
  end

  initial begin : stimulus
    item_t       it;
    logic [63:0] thr;
    int          pick, c, r, k, idx, miss;
    int          dc [5] = '{0, -1, 1, 0, 0};
    int          dr [5] = '{0, 0, 0, -1, 1};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      // thresholds change only with the block drained
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      thr = PHASE_THR[phase];
      if (phase == N_PHASES - 1) thr = {$urandom, $urandom};
      write_threshold(CFG_THR_TWO, thr[63:32]);
      write_threshold(CFG_THR_FOUR, thr[31:0]);
      cfg_valid <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm <= (phase == 1 && n < 100);
        pick = $urandom_range(0, 99);
        // trials mostly inside an 8 x 8 window that straddles the wrap
        if ($urandom_range(0, 4) != 0) begin
          c = (124 + $urandom_range(0, 7)) % SIDE;
          r = (124 + $urandom_range(0, 7)) % SIDE;
        end else begin
          c = $urandom_range(0, SIDE - 1);
          r = $urandom_range(0, SIDE - 1);
        end
        it.col  = 7'(c);
        it.row  = 7'(r);
        it.spin = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0:       it.rnd = '0;
          1:       it.rnd = '1;
          2:       it.rnd = $urandom_range(0, 1) ? thr_two : thr_four;
          3:       it.rnd = ($urandom_range(0, 1) ? thr_two : thr_four) + 1;
          default: it.rnd = $urandom;
        endcase
        if (pick < 5) begin
          it.cmd = CMD_NONE;
        end else if (pick < 10) begin
          it.cmd = CMD_REPORT;
        end else if (pick < 30) begin
          it.cmd = CMD_LOAD;
        end else begin
          // a trial needs the site and its four neighbors loaded
          miss = -1;
          for (k = 0; k < 5; k++) begin
            idx = ((r + dr[k] + SIDE) % SIDE) * SIDE + (c + dc[k] + SIDE) % SIDE;
            if (!lattice_loaded[idx] && miss < 0) miss = idx;
          end
          if (miss < 0) begin
            it.cmd = CMD_TRIAL;
          end else begin
            it.cmd = CMD_LOAD;
            it.col = 7'(miss % SIDE);
            it.row = 7'(miss / SIDE);
          end
        end
        send_item(it, 1'b0, RES_ZERO);
      end
    end

    // drain, then give the pipeline time to show stray beats
    in_valid <= 1'b0;
    calm     <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("** ising_metropolis_spin_update: PASSED **");
    else
      $display("** ising_metropolis_spin_update: FAILED **");
    $finish;
  end

endmodule

[sim.f]
design/ims_pkg.sv
design/ims_ctrl.sv
design/ims_dp.sv
design/ising_metropolis_spin_update.sv
tb/tb_ising_metropolis_spin_update.sv
